// ----- rtl/acpu_pkg.sv -----
// Package with the opcode type, sizes and constants of the accumulator CPU executor.
package acpu_pkg;

  localparam int RAM_DEPTH  = 1024;
  localparam int REG_COUNT  = 4;
  localparam int NUM_PORTS  = 8;
  localparam int DISK_DEPTH = 1024;

  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int DISK_AW   = $clog2(DISK_DEPTH);
  localparam int CLR_DEPTH = (RAM_DEPTH > DISK_DEPTH) ? RAM_DEPTH : DISK_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);
  localparam int REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  typedef enum logic [3:0] {
    OP_LDI = 4'd0,
    OP_RST = 4'd1,
    OP_RLD = 4'd2,
    OP_PST = 4'd3,
    OP_PLD = 4'd4,
    OP_STR = 4'd5,
    OP_LOD = 4'd6,
    OP_DST = 4'd7,
    OP_DLD = 4'd8,
    OP_BRC = 4'd9,
    OP_ADD = 4'd10,
    OP_SUB = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13,
    OP_OPS = 4'd14,
    OP_OPL = 4'd15
  } op_t;

  localparam logic [7:0] FLAG_ALWAYS = 8'd0;
  localparam logic [7:0] FLAG_ZERO   = 8'd1;
  localparam logic [7:0] FLAG_CARRY  = 8'd2;
  localparam logic [7:0] SAVE_SLOTS  = 8'd2;
  localparam logic [1:0] OVR_START   = 2'd2;

endpackage

// ----- rtl/accumulator_cpu_executor.sv -----
// Top level of the accumulator CPU executor: one decoded instruction per request.
// Each request is registered, then its result is registered onto the outputs; LOD and DLD
// first wait for the registered RAM/disk read. One request per cycle is taken while out_ready
// holds and no load is pending. Reset clears all architectural state, then a clearing pass
// zeroes RAM and disk, one entry of each per cycle, during which no request is accepted.
module accumulator_cpu_executor
  import acpu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_operand_a,
  input  logic [7:0]  in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_pc,
  output logic [7:0]  out_accumulator,
  output logic        out_zero_flag,
  output logic        out_carry_flag,
  output logic        out_port_write,
  output logic [2:0]  out_port_index,
  output logic [7:0]  out_port_value,
  output logic        out_range_error
);

  logic             in_valid_r;
  logic [3:0]       kind_r;
  logic [7:0]       a_raw_r;
  logic [7:0]       b_raw_r;
  logic             rd_pend_r;
  logic             clr_busy_r;
  logic [CLR_AW-1:0] clr_cnt_r;

  logic [15:0]      pc_r;
  logic [7:0]       acc_r;
  logic [7:0]       gregs_r [REG_COUNT];
  logic             zero_r;
  logic             carry_r;
  logic [7:0]       saved_r [2];
  logic [1:0]       ovr_r;
  logic [7:0]       ports_r [NUM_PORTS];

  logic [7:0]       ram_mem  [RAM_DEPTH];
  logic [7:0]       disk_mem [DISK_DEPTH];
  logic [7:0]       ram_rd_r;
  logic [7:0]       disk_rd_r;

  logic             out_valid_r;
  logic [15:0]      out_next_pc_r;
  logic [7:0]       out_acc_r;
  logic             out_zero_r;
  logic             out_carry_r;
  logic             out_pw_r;
  logic [2:0]       out_pidx_r;
  logic [7:0]       out_pval_r;
  logic             out_err_r;

  op_t              op;
  logic             is_load;
  logic             commit;
  logic             ld_issue;
  logic [1:0]       ovr_dec;
  logic             use_saved;
  logic [7:0]       op_a;
  logic [7:0]       op_b;
  logic [15:0]      addr;
  logic             ram_ok;
  logic             disk_ok;
  logic             reg_ok;
  logic             port_ok;
  logic [7:0]       reg_val;
  logic [7:0]       port_val;

  logic [15:0]      pc_nxt;
  logic [7:0]       acc_nxt;
  logic             zero_nxt;
  logic             carry_nxt;
  logic [1:0]       ovr_nxt;
  logic             pw_nxt;
  logic [2:0]       pidx_nxt;
  logic [7:0]       pval_nxt;
  logic             err_nxt;
  logic             reg_we;
  logic             port_we;
  logic             ram_we_op;
  logic             disk_we_op;
  logic             ops_we;
  logic             set_flags;
  logic [9:0]       alu_v;

  logic             ram_we;
  logic             disk_we;
  logic [RAM_AW-1:0]  ram_wa;
  logic [DISK_AW-1:0] disk_wa;
  logic [7:0]       mem_wd;

  assign op       = op_t'(kind_r);
  assign is_load  = (op == OP_LOD) || (op == OP_DLD);
  assign commit   = in_valid_r && (!is_load || rd_pend_r) && (!out_valid_r || out_ready);
  assign ld_issue = in_valid_r && is_load && !rd_pend_r;
  assign in_ready = !clr_busy_r && (!in_valid_r || commit);

  assign ovr_dec   = (ovr_r != 2'd0) ? ovr_r - 2'd1 : 2'd0;
  assign use_saved = (ovr_dec != 2'd0);
  assign op_a      = use_saved ? saved_r[0] : a_raw_r;
  assign op_b      = use_saved ? saved_r[1] : b_raw_r;
  assign addr      = {op_a, op_b};
  assign ram_ok    = {1'b0, addr} < 17'(RAM_DEPTH);
  assign disk_ok   = {1'b0, addr} < 17'(DISK_DEPTH);
  assign reg_ok    = {1'b0, op_a} < 9'(REG_COUNT);
  assign port_ok   = {1'b0, op_a} < 9'(NUM_PORTS);
  assign reg_val   = reg_ok ? gregs_r[op_a[REG_AW-1:0]] : 8'd0;
  assign port_val  = port_ok ? ports_r[op_a[PORT_AW-1:0]] : 8'd0;

  always_comb begin
    pc_nxt     = pc_r + 16'd1;
    acc_nxt    = acc_r;
    zero_nxt   = zero_r;
    carry_nxt  = carry_r;
    ovr_nxt    = ovr_dec;
    pw_nxt     = 1'b0;
    pidx_nxt   = 3'd0;
    pval_nxt   = 8'd0;
    err_nxt    = 1'b0;
    reg_we     = 1'b0;
    port_we    = 1'b0;
    ram_we_op  = 1'b0;
    disk_we_op = 1'b0;
    ops_we     = 1'b0;
    set_flags  = 1'b0;
    alu_v      = 10'd0;
    case (op)
      OP_LDI: begin
        set_flags = 1'b1;
        alu_v     = {2'b00, op_a};
      end
      OP_RST: begin
        reg_we  = reg_ok;
        err_nxt = !reg_ok;
      end
      OP_RLD: begin
        acc_nxt = reg_val;
        err_nxt = !reg_ok;
      end
      OP_PST: begin
        port_we  = port_ok;
        err_nxt  = !port_ok;
        pw_nxt   = port_ok;
        pidx_nxt = port_ok ? op_a[2:0] : 3'd0;
        pval_nxt = port_ok ? acc_r : 8'd0;
      end
      OP_PLD: begin
        acc_nxt = port_val;
        err_nxt = !port_ok;
      end
      OP_STR: begin
        ram_we_op = ram_ok;
        err_nxt   = !ram_ok;
      end
      OP_LOD: begin
        acc_nxt = ram_ok ? ram_rd_r : 8'd0;
        err_nxt = !ram_ok;
      end
      OP_DST: begin
        disk_we_op = disk_ok;
        err_nxt    = !disk_ok;
      end
      OP_DLD: begin
        acc_nxt = disk_ok ? disk_rd_r : 8'd0;
        err_nxt = !disk_ok;
      end
      OP_BRC: begin
        if ((op_a == FLAG_ALWAYS) || ((op_a == FLAG_ZERO) && zero_r) ||
            ((op_a == FLAG_CARRY) && carry_r)) begin
          pc_nxt = {8'd0, op_b};
        end
      end
      OP_ADD: begin
        set_flags = 1'b1;
        alu_v     = {2'b00, acc_r} + {2'b00, reg_val};
        err_nxt   = !reg_ok;
      end
      OP_SUB: begin
        set_flags = 1'b1;
        alu_v     = {2'b00, acc_r} - {2'b00, reg_val};
        err_nxt   = !reg_ok;
      end
      OP_INC: begin
        set_flags = 1'b1;
        alu_v     = {2'b00, acc_r} + 10'd1;
      end
      OP_DEC: begin
        set_flags = 1'b1;
        alu_v     = {2'b00, acc_r} - 10'd1;
      end
      OP_OPS: begin
        ops_we = (a_raw_r < SAVE_SLOTS);
      end
      OP_OPL: begin
        ovr_nxt = OVR_START;
      end
      default: begin
      end
    endcase
    if (set_flags) begin
      zero_nxt  = (alu_v == 10'd0);
      carry_nxt = alu_v[9] | alu_v[8];
      acc_nxt   = alu_v[7:0];
    end
  end

  assign ram_we  = clr_busy_r ? ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(RAM_DEPTH))
                              : (commit && ram_we_op);
  assign disk_we = clr_busy_r ? ({1'b0, clr_cnt_r} < (CLR_AW + 1)'(DISK_DEPTH))
                              : (commit && disk_we_op);
  assign ram_wa  = clr_busy_r ? clr_cnt_r[RAM_AW-1:0] : addr[RAM_AW-1:0];
  assign disk_wa = clr_busy_r ? clr_cnt_r[DISK_AW-1:0] : addr[DISK_AW-1:0];
  assign mem_wd  = clr_busy_r ? 8'd0 : acc_r;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_wa] <= mem_wd;
    end
    if (ld_issue && (op == OP_LOD)) begin
      ram_rd_r <= ram_mem[addr[RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (disk_we) begin
      disk_mem[disk_wa] <= mem_wd;
    end
    if (ld_issue && (op == OP_DLD)) begin
      disk_rd_r <= disk_mem[addr[DISK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + CLR_AW'(1);
      if (clr_cnt_r == CLR_AW'(CLR_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      rd_pend_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (commit) begin
        in_valid_r <= 1'b0;
      end
      if (commit) begin
        rd_pend_r <= 1'b0;
      end else if (ld_issue) begin
        rd_pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      a_raw_r <= in_operand_a;
      b_raw_r <= in_operand_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 16'd0;
      acc_r   <= 8'd0;
      zero_r  <= 1'b0;
      carry_r <= 1'b0;
      ovr_r   <= 2'd0;
      for (int i = 0; i < REG_COUNT; i++) begin
        gregs_r[i] <= 8'd0;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        ports_r[i] <= 8'd0;
      end
      saved_r[0] <= 8'd0;
      saved_r[1] <= 8'd0;
    end else if (commit) begin
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      zero_r  <= zero_nxt;
      carry_r <= carry_nxt;
      ovr_r   <= ovr_nxt;
      if (reg_we) begin
        gregs_r[op_a[REG_AW-1:0]] <= acc_r;
      end
      if (port_we) begin
        ports_r[op_a[PORT_AW-1:0]] <= acc_r;
      end
      if (ops_we) begin
        saved_r[a_raw_r[0]] <= acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_next_pc_r <= pc_nxt;
      out_acc_r     <= acc_nxt;
      out_zero_r    <= zero_nxt;
      out_carry_r   <= carry_nxt;
      out_pw_r      <= pw_nxt;
      out_pidx_r    <= pidx_nxt;
      out_pval_r    <= pval_nxt;
      out_err_r     <= err_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_next_pc_r;
  assign out_accumulator = out_acc_r;
  assign out_zero_flag   = out_zero_r;
  assign out_carry_flag  = out_carry_r;
  assign out_port_write  = out_pw_r;
  assign out_port_index  = out_pidx_r;
  assign out_port_value  = out_pval_r;
  assign out_range_error = out_err_r;

endmodule
